// File: src/fbrps_pkg.sv
// Shared types and constants for the byte-range page splitter.
`timescale 1ns / 1ps
`default_nettype none

package fbrps_pkg;

    localparam int MAX_OPS_DEFAULT = 64;
    localparam int MAX_PAGE_BYTES  = 2048;

    localparam int LG_W   = 4;
    localparam int LG_MIN = 8;
    localparam int LG_MAX = 11;
    localparam int LG_FLOOR = $clog2(MAX_PAGE_BYTES + 1) - 1;
    localparam int LG_TOP = (LG_FLOOR < LG_MIN) ? LG_MIN :
                            ((LG_FLOOR > LG_MAX) ? LG_MAX : LG_FLOOR);
    localparam logic [LG_W-1:0] CFG_RESET = 4'd9;

    localparam int OFF_W   = 25;
    localparam int LEN_W   = 14;
    localparam int PAGE_W  = 17;
    localparam int START_W = 11;
    localparam int CNT_W   = 12;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef struct packed {
        logic               action;
        logic [OFF_W-1:0]   byte_offset;
        logic [LEN_W-1:0]   length;
        logic [LEN_W-1:0]   buffer_limit;
    } t_req;

    typedef struct packed {
        logic [PAGE_W-1:0]  page_number;
        logic [START_W-1:0] start_in_page;
        logic [CNT_W-1:0]   byte_count;
        logic [LEN_W-1:0]   data_offset;
        logic               read_first;
        logic               program_page;
        logic               last_op;
    } t_op;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic empty;
        logic last;
    } t_status;

endpackage

`default_nettype wire

// File: src/fbrps_ctrl.sv
// Controller state machine: request acceptance and page operation sequencing.
`timescale 1ns / 1ps
`default_nettype none

module fbrps_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  fbrps_pkg::t_status i_status,
    output fbrps_pkg::t_cmd  o_cmd
);
    import fbrps_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_status.empty) begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (i_status.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_status.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step && i_status.last) |=> (r_state == ST_IDLE))
        else $error("run did not end after last word");

    a_no_load_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (!o_cmd.load && o_in_stall))
        else $error("request taken during run");

endmodule

`default_nettype wire

// File: src/fbrps_dp.sv
// Datapath: page size register, request registers, operation generator, output word.
`timescale 1ns / 1ps
`default_nettype none

module fbrps_dp #(
    parameter int MAX_OPS = fbrps_pkg::MAX_OPS_DEFAULT
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire [fbrps_pkg::LG_W-1:0] i_cfg_data,
    input  fbrps_pkg::t_req  i_req,
    input  fbrps_pkg::t_cmd  i_cmd,
    output fbrps_pkg::t_status o_status,
    input  wire              i_out_stall,
    output logic             o_out_valid,
    output fbrps_pkg::t_op   o_out_word
);
    import fbrps_pkg::*;

    localparam int N_W = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
    localparam logic [N_W-1:0] N_LAST = N_W'(MAX_OPS - 1);

    logic [LG_W-1:0]    r_lg_cfg;
    logic               r_wr;
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   r_done;
    logic [PAGE_W-1:0]  r_page;
    logic [START_W-1:0] r_start;
    logic [CNT_W-1:0]   r_ps;
    logic [N_W-1:0]     r_n;
    logic               r_out_valid;
    t_op                r_out;

    logic [LG_W-1:0]    lg_eff;
    logic [LEN_W-1:0]   len_eff;
    logic [START_W-1:0] rem_in;
    logic [PAGE_W-1:0]  page_in;
    logic [CNT_W-1:0]   ps_in;
    logic [LEN_W-1:0]   remaining;
    logic [CNT_W-1:0]   avail;
    logic [CNT_W-1:0]   count;
    logic               middle;
    logic               last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lg_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_lg_cfg <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_lg_cfg < LG_W'(LG_MIN)) begin
            lg_eff = LG_W'(LG_MIN);
        end else if (r_lg_cfg > LG_W'(LG_TOP)) begin
            lg_eff = LG_W'(LG_TOP);
        end else begin
            lg_eff = r_lg_cfg;
        end
        if (i_req.action == ACT_READ && i_req.length > i_req.buffer_limit) begin
            len_eff = i_req.buffer_limit;
        end else begin
            len_eff = i_req.length;
        end
        ps_in   = CNT_W'(1) << lg_eff;
        rem_in  = START_W'(i_req.byte_offset & (OFF_W'(ps_in) - OFF_W'(1)));
        page_in = PAGE_W'(i_req.byte_offset >> lg_eff);
    end

    always_comb begin
        remaining = r_len - r_done;
        avail     = r_ps - {1'b0, r_start};
        if ({2'b00, avail} > remaining) begin
            count = CNT_W'(remaining);
        end else begin
            count = avail;
        end
        middle = (r_start == '0) && (remaining >= {2'b00, r_ps});
        last   = (r_n == N_LAST) || ({2'b00, count} == remaining);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_wr    <= i_req.action;
            r_len   <= len_eff;
            r_done  <= '0;
            r_page  <= page_in;
            r_start <= rem_in;
            r_ps    <= ps_in;
        end else if (i_cmd.step) begin
            r_page  <= r_page + PAGE_W'(1);
            r_done  <= r_done + LEN_W'(count);
            r_start <= '0;
        end
        if (i_cmd.step) begin
            r_out.page_number   <= r_page;
            r_out.start_in_page <= r_start;
            r_out.byte_count    <= count;
            r_out.data_offset   <= r_done;
            r_out.read_first    <= middle ? !r_wr : 1'b1;
            r_out.program_page  <= r_wr;
            r_out.last_op       <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_n <= '0;
            end else if (i_cmd.step) begin
                r_n <= r_n + N_W'(1);
            end
            if (i_cmd.step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_status.empty    = (len_eff == '0) && (rem_in == '0);
    assign o_status.last     = last;
    assign o_out_valid       = r_out_valid;
    assign o_out_word        = r_out;

    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> o_out_valid)
        else $error("step did not produce an output word");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && !last) |=> (r_done == $past(r_done + LEN_W'(count)))
                                  && (r_done != $past(r_done)))
        else $error("run did not advance");

endmodule

`default_nettype wire

// File: src/flash_byte_range_page_splitter.sv
// Top level: byte-range request to flash page operation splitter.
//
//  channel  | direction | handshake                      | word
//  request  | in        | i_in_valid / o_in_stall        | i_in_word  (t_req)
//  page op  | out       | o_out_valid / i_out_stall      | o_out_word (t_op)
//  config   | in        | i_cfg_we                       | i_cfg_data (page_size_log2)
//
// A request is taken and then holds the input while its k page words leave, one
// per cycle unless the output stalls; k (at most MAX_OPS_PER_REQUEST) is set by
// offset, length and page size.
// An aligned zero-length request gives no word and frees the input at once.
// Reset is synchronous and active low; the page size register resets to 9.
// A stall on the output holds the output word and pauses the page sequence.
`timescale 1ns / 1ps
`default_nettype none

module flash_byte_range_page_splitter #(
    parameter int MAX_OPS_PER_REQUEST = fbrps_pkg::MAX_OPS_DEFAULT
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire [fbrps_pkg::LG_W-1:0] i_cfg_data,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  fbrps_pkg::t_req  i_in_word,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output fbrps_pkg::t_op   o_out_word
);
    import fbrps_pkg::*;

    t_cmd    cmd;
    t_status status;

    fbrps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    fbrps_dp #(
        .MAX_OPS (MAX_OPS_PER_REQUEST)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_in_word),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

// File: test/page_op_checker.sv
// Checker for the page splitter: predicts page op words per request and compares them.
`timescale 1ns / 1ps

module page_op_checker #(
    parameter int MAX_OPS = fbrps_pkg::MAX_OPS_DEFAULT
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire [fbrps_pkg::LG_W-1:0]   i_cfg_data,
    input  wire                         i_in_valid,
    input  wire                         i_in_stall,
    input  fbrps_pkg::t_req             i_in_word,
    input  wire                         i_out_valid,
    input  wire                         i_out_stall,
    input  fbrps_pkg::t_op              i_out_word,
    output int                          o_pending,
    output int                          o_fails
);
    import fbrps_pkg::*;

    logic [LG_W-1:0] page_log2_reg = CFG_RESET;
    t_op             expected_ops[$];
    int              fails = 0;

    function automatic t_op make_op(input int unsigned page, input int unsigned start,
                                    input int unsigned count, input int unsigned doff,
                                    input logic rd, input logic pg);
        t_op op;
        op.page_number   = page[PAGE_W-1:0];
        op.start_in_page = start[START_W-1:0];
        op.byte_count    = count[CNT_W-1:0];
        op.data_offset   = doff[LEN_W-1:0];
        op.read_first    = rd;
        op.program_page  = pg;
        op.last_op       = 1'b0;
        return op;
    endfunction

    function automatic void split_request(input t_req req, input logic [LG_W-1:0] lg_reg);
        t_op         ops[MAX_OPS];
        int unsigned lg, ps, rem, len, done, page, first, n;
        logic        wr;
        wr = (req.action == ACT_WRITE);
        lg = 32'(lg_reg);
        if (lg < LG_MIN) lg = LG_MIN;
        if (lg > LG_MAX) lg = LG_MAX;
        while (lg > LG_MIN && (32'd1 << lg) > MAX_PAGE_BYTES) lg = lg - 1;
        ps = 32'd1 << lg;
        len = 32'(req.length);
        if (!wr && len > 32'(req.buffer_limit)) len = 32'(req.buffer_limit);
        rem = 32'(req.byte_offset) & (ps - 1);
        page = 32'(req.byte_offset) >> lg;
        done = 0;
        n = 0;
        if (rem > 0) begin
            first = ps - rem;
            if (len < first) first = len;
            ops[n] = make_op(page, rem, first, 0, 1'b1, wr);
            n = n + 1;
            page = page + 1;
            done = done + first;
        end
        while (len - done >= ps && n < MAX_OPS) begin
            ops[n] = make_op(page, 0, ps, done, !wr, wr);
            n = n + 1;
            page = page + 1;
            done = done + ps;
        end
        if (len > done && len - done < ps && n < MAX_OPS) begin
            ops[n] = make_op(page, 0, len - done, done, 1'b1, wr);
            n = n + 1;
        end
        if (n > 0) ops[n - 1].last_op = 1'b1;
        for (int i = 0; i < n; i++) expected_ops.push_back(ops[i]);
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_op want;
        if (!i_rst_n) begin
            page_log2_reg = CFG_RESET;
        end else begin
            if (i_in_valid && !i_in_stall) split_request(i_in_word, page_log2_reg);
            if (i_cfg_we) page_log2_reg = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (expected_ops.size() == 0) begin
                    $error("unexpected page op word: page %0d, count %0d",
                           i_out_word.page_number, i_out_word.byte_count);
                    fails++;
                end else begin
                    want = expected_ops.pop_front();
                    compare_field("page_number", 32'(want.page_number),
                                  32'(i_out_word.page_number));
                    compare_field("start_in_page", 32'(want.start_in_page),
                                  32'(i_out_word.start_in_page));
                    compare_field("byte_count", 32'(want.byte_count),
                                  32'(i_out_word.byte_count));
                    compare_field("data_offset", 32'(want.data_offset),
                                  32'(i_out_word.data_offset));
                    compare_field("read_first", 32'(want.read_first),
                                  32'(i_out_word.read_first));
                    compare_field("program_page", 32'(want.program_page),
                                  32'(i_out_word.program_page));
                    compare_field("last_op", 32'(want.last_op), 32'(i_out_word.last_op));
                end
            end
        end
        o_pending <= expected_ops.size();
        o_fails   <= fails;
    end

endmodule

// File: test/testbench.sv
// Top of the page splitter testbench: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import fbrps_pkg::*;

    localparam int    SETTLE_CYCLES = 80;
    localparam int    HOLD_CYCLES   = 300;
    localparam int    LEN_TOP       = 16128;

    logic            i_clk = 1'b0;
    logic            rst_n;
    logic            cfg_we;
    logic [LG_W-1:0] cfg_data;
    logic            in_valid;
    logic            in_stall;
    t_req            in_word;
    logic            out_valid;
    logic            out_stall;
    t_op             out_word;
    int              pending_ops;
    int              fail_count;

    int              snd_idle_pct = 7;
    int              rcv_idle_pct = 88;
    logic            hold_go = 1'b0;
    int unsigned     cur_ps = 512;

    always #5 i_clk = ~i_clk;

    flash_byte_range_page_splitter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    page_op_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_word   (in_word),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_word  (out_word),
        .o_pending   (pending_ops),
        .o_fails     (fail_count)
    );

    // receiver side: random stall, or one long hold-off on request
    initial begin : receiver
        bit held;
        held      = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !held) begin
                held      = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                out_stall <= ($urandom_range(99, 0) < rcv_idle_pct);
            end
        end
    end

    initial begin
        #40_000_000;
        $display("testbench failed");
        $finish;
    end

    function automatic t_req make_req(input logic act, input int unsigned off,
                                      input int unsigned len, input int unsigned lim);
        t_req r;
        r.action       = act;
        r.byte_offset  = off[OFF_W-1:0];
        r.length       = len[LEN_W-1:0];
        r.buffer_limit = lim[LEN_W-1:0];
        return r;
    endfunction

    function automatic t_req gen_request(input int unsigned ps);
        int unsigned off, len, lim, pick;
        logic        act;
        act  = 1'($urandom_range(1, 0));
        pick = $urandom_range(99, 0);
        off  = $urandom & 32'h01FF_FFFF;
        if (pick < 30)
            off = off & ~(ps - 1);
        else if (pick < 45)
            off = (off & ~(ps - 1)) + ps - $urandom_range(4, 1);
        else if (pick < 55)
            off = 32'h0200_0000 - $urandom_range(3 * ps, 1);
        pick = $urandom_range(99, 0);
        if (pick < 8)
            len = 0;
        else if (pick < 83)
            len = $urandom_range(3 * ps, 1);
        else if (pick < 95)
            len = $urandom_range(LEN_TOP, 0);
        else
            len = ps * $urandom_range(4, 1);
        pick = $urandom_range(99, 0);
        if (pick < 50)
            lim = $urandom_range(LEN_TOP, 0);
        else if (pick < 80)
            lim = len + $urandom_range(3, 0);
        else
            lim = $urandom_range(len, 0);
        if (lim > LEN_TOP) lim = LEN_TOP;
        return make_req(act, off, len, lim);
    endfunction

    task automatic send_request(input t_req req);
        if (snd_idle_pct != 0 && $urandom_range(99, 0) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99, 0) < snd_idle_pct) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= req;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_ops != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_page_log2(input logic [LG_W-1:0] value);
        int unsigned lg;
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        lg = 32'(value);
        if (lg < LG_MIN) lg = LG_MIN;
        if (lg > LG_MAX) lg = LG_MAX;
        cur_ps = 32'd1 << lg;
    endtask

    task automatic run_random(input int count);
        repeat (count) send_request(gen_request(cur_ps));
    endtask

    task automatic run_directed();
        send_request(make_req(ACT_READ,  0, 0, 0));
        send_request(make_req(ACT_WRITE, 0, 0, 0));
        send_request(make_req(ACT_READ,  5, 0, 100));
        send_request(make_req(ACT_WRITE, 511, 0, 0));
        send_request(make_req(ACT_READ,  0, 1, LEN_TOP));
        send_request(make_req(ACT_WRITE, 0, 512, 0));
        send_request(make_req(ACT_WRITE, 1, 511, 0));
        send_request(make_req(ACT_WRITE, 100, 1000, 0));
        send_request(make_req(ACT_READ,  100, 1000, 300));
        send_request(make_req(ACT_READ,  512, 1000, 0));
        send_request(make_req(ACT_READ,  3, 1000, 0));
        send_request(make_req(ACT_READ,  32'h01FF_FFFF, LEN_TOP, LEN_TOP));
        send_request(make_req(ACT_WRITE, 32'h01FF_FFFF, LEN_TOP, 0));
        send_request(make_req(ACT_WRITE, 0, LEN_TOP, LEN_TOP));
        send_request(make_req(ACT_READ,  32'h01FF_FE00, 2048, LEN_TOP));
        send_request(make_req(ACT_WRITE, 511, 2, 5));
        send_request(make_req(ACT_READ,  32'h0155_5555, 32'h2AAA, 32'h1555));
        send_request(make_req(ACT_WRITE, 32'h00AA_AAAA, 32'h1555, 32'h2AAA));
        send_request(make_req(ACT_READ,  1000, LEN_TOP, LEN_TOP - 1));
        send_request(make_req(ACT_WRITE, 512, 511, 0));
    endtask

    initial begin
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_word  = '0;
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        snd_idle_pct = 7;
        rcv_idle_pct = 88;
        run_directed();

        // run limit at the smallest page
        write_page_log2(4'd8);
        send_request(make_req(ACT_WRITE, 1, 32'h3FFF, 0));
        send_request(make_req(ACT_READ,  1, 32'h3FFF, 32'h3FFF));
        send_request(make_req(ACT_READ,  0, 32'h3FFF, 32'h3FFF));
        run_random(70);
        write_page_log2(4'd11);
        run_random(60);

        write_page_log2(4'd10);
        snd_idle_pct = 88;
        rcv_idle_pct = 7;
        run_random(60);
        write_page_log2(4'd0);
        run_random(50);

        write_page_log2(4'd15);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_go <= 1'b1;
        run_random(60);
        write_page_log2(4'd9);
        run_random(50);
        write_page_log2(LG_W'($urandom_range(15, 0)));
        run_random(60);

        drain();
        if (fail_count == 0 && pending_ops == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/fbrps_pkg.sv
src/fbrps_ctrl.sv
src/fbrps_dp.sv
src/flash_byte_range_page_splitter.sv
test/page_op_checker.sv
test/testbench.sv
